### hdl/min_coin_change_table_defines.svh
// Assertion macros used by the checker file of the coin change table.
`ifndef MIN_COIN_CHANGE_TABLE_DEFINES_SVH
`define MIN_COIN_CHANGE_TABLE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define MCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mcc_pkg.sv
// Package with the types and constants of the coin change table.
`timescale 1ns / 1ps

package mcc_pkg;

    localparam int NUM_COINS   = 6;
    localparam int VALUE_W     = 7;
    localparam int KINDS_W     = 3;
    localparam int FIELD_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] REG_COIN_KINDS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_4 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_5 = 3'd6;

    localparam logic [KINDS_W-1:0] RST_COIN_KINDS = 3'd3;
    localparam logic [NUM_COINS-1:0][VALUE_W-1:0] RST_COIN_VALUES =
        {7'd1, 7'd1, 7'd1, 7'd7, 7'd3, 7'd1};

    typedef struct packed {
        logic [KINDS_W-1:0]                   kinds;
        logic [NUM_COINS-1:0][VALUE_W-1:0]    value;
    } t_cfg;

endpackage

### hdl/mcc_cfg.sv
// Configuration register file of the coin change table.
`timescale 1ns / 1ps

module mcc_cfg
    import mcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kinds <= RST_COIN_KINDS;
            r_cfg.value <= RST_COIN_VALUES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COIN_KINDS:   r_cfg.kinds    <= i_cfg_data[KINDS_W-1:0];
                REG_COIN_VALUE_0: r_cfg.value[0] <= i_cfg_data;
                REG_COIN_VALUE_1: r_cfg.value[1] <= i_cfg_data;
                REG_COIN_VALUE_2: r_cfg.value[2] <= i_cfg_data;
                REG_COIN_VALUE_3: r_cfg.value[3] <= i_cfg_data;
                REG_COIN_VALUE_4: r_cfg.value[4] <= i_cfg_data;
                REG_COIN_VALUE_5: r_cfg.value[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/min_coin_change_table.sv
// A new request is taken only in the idle state, so one request is in work at a time: the idle
// state takes the request, the single read port visits one denomination per cycle, a drain
// state waits for the last read and a final state writes the row back; a held result stalls
// the write-back. An amount past MAX_AMOUNT goes from the idle state straight to the final state.
// Reset restores the register defaults and the amount counter to 1; the row memory is
// not cleared, every row is written before use.
`timescale 1ns / 1ps

module min_coin_change_table
    import mcc_pkg::*;
#(
    parameter int MAX_AMOUNT = 64,
    parameter int MAX_KINDS  = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] restart, [7:1] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [6:0] amount, [7] reachable, [14:8] fewest_coins, [21:15] uses_0,
    // [28:22] uses_1, [35:29] uses_2, [42:36] uses_3, [49:43] uses_4,
    // [56:50] uses_5, [62:57] optimal_choices, [63] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] table_full
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(MAX_AMOUNT + 2);
    localparam int CW = $clog2(MAX_AMOUNT + 1);
    localparam int IW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT) : 1;
    localparam int JW = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
    localparam int DW = (AW > VALUE_W) ? AW : VALUE_W;
    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

    typedef struct packed {
        logic                           reach;
        logic [CW-1:0]                  fewest;
        logic [MAX_KINDS-1:0][CW-1:0]   uses;
    } t_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    t_cfg cfg;

    t_row r_row_mem [MAX_AMOUNT];
    t_row r_rd_q;

    t_state                         r_state;
    logic [AW-1:0]                  r_amount;
    logic [AW-1:0]                  r_cur;
    logic                           r_full;
    logic [JW-1:0]                  r_j;
    logic                           r_rd_pend;
    logic                           r_rd_base;
    logic [JW-1:0]                  r_rd_j;
    logic                           r_found;
    logic [CW-1:0]                  r_best;
    logic [NUM_COINS-1:0]           r_choices;
    logic [JW-1:0]                  r_last;
    logic [MAX_KINDS-1:0][CW-1:0]   r_last_uses;
    logic                           r_m_valid;
    logic [M_TDATA_W-1:0]           r_m_data;
    logic                           r_m_user;

    logic [AW-1:0]                  n_cur;
    logic [VALUE_W-1:0]             coin;
    logic [DW-1:0]                  pred;
    logic                           coin_use;
    logic                           pred_base;
    logic                           rd_en;
    logic [IW-1:0]                  rd_addr;
    t_row                           rd_row;
    logic [CW-1:0]                  cand;
    logic                           take_new;
    logic                           take_tie;
    t_row                           wr_row;
    logic [IW-1:0]                  wr_addr;
    logic                           out_free;
    logic [DW-1:0]                  cur_ext;
    logic [XW-1:0]                  best_ext;
    logic [NUM_COINS-1:0][FIELD_W-1:0] uses_out;
    logic [M_TDATA_W-1:0]           data_out;

    mcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign n_cur = s_axis_tdata[0] ? AW'(1) : r_amount;

    // Issue side: one denomination per cycle.
    always_comb begin
        coin      = cfg.value[r_j];
        cur_ext   = DW'(r_cur);
        coin_use  = (KINDS_W'(r_j) < cfg.kinds) && (coin != '0)
                    && (DW'(coin) <= cur_ext);
        pred      = cur_ext - DW'(coin);
        pred_base = (pred == '0);
        rd_en     = (r_state == ST_SCAN) && coin_use && !pred_base;
        rd_addr   = IW'(pred - DW'(1));
    end

    // Evaluate side: the row read in the previous cycle.
    always_comb begin
        if (r_rd_base) begin
            rd_row       = '0;
            rd_row.reach = 1'b1;
        end else begin
            rd_row = r_rd_q;
        end
        cand     = rd_row.fewest + CW'(1);
        take_new = r_rd_pend && rd_row.reach && (!r_found || cand < r_best);
        take_tie = r_rd_pend && rd_row.reach && r_found && (cand == r_best);
    end

    always_comb begin
        wr_row        = '0;
        wr_row.reach  = r_found;
        wr_row.fewest = r_found ? r_best : '0;
        for (int k = 0; k < MAX_KINDS; k++) begin
            wr_row.uses[k] = r_found
                ? r_last_uses[k] + CW'(r_last == JW'(k))
                : '0;
        end
        wr_addr  = IW'(r_cur - AW'(1));
        best_ext = XW'(wr_row.fewest);
        for (int k = 0; k < NUM_COINS; k++) begin
            uses_out[k] = '0;
            if (k < MAX_KINDS) begin
                uses_out[k] = FIELD_W'(XW'(wr_row.uses[k]));
            end
        end
        data_out        = '0;
        data_out[6:0]   = cur_ext[FIELD_W-1:0];
        data_out[7]     = r_found;
        data_out[14:8]  = best_ext[FIELD_W-1:0];
        data_out[56:15] = uses_out;
        data_out[62:57] = r_choices;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_row_mem[rd_addr];
        end
        if ((r_state == ST_FIN) && out_free && !r_full) begin
            r_row_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_amount  <= AW'(1);
            r_rd_pend <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != ST_FIN)) begin
                r_m_valid <= 1'b0;
            end
            if (take_new) begin
                r_found     <= 1'b1;
                r_best      <= cand;
                r_choices   <= NUM_COINS'(1) << r_rd_j;
                r_last      <= r_rd_j;
                r_last_uses <= rd_row.uses;
            end else if (take_tie) begin
                r_choices   <= r_choices | (NUM_COINS'(1) << r_rd_j);
                r_last      <= r_rd_j;
                r_last_uses <= rd_row.uses;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cur     <= n_cur;
                        r_amount  <= n_cur;
                        r_j       <= '0;
                        r_rd_pend <= 1'b0;
                        r_found   <= 1'b0;
                        r_choices <= '0;
                        r_last    <= '0;
                        if (n_cur > AW'(MAX_AMOUNT)) begin
                            r_full  <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_full  <= 1'b0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_pend <= coin_use;
                    r_rd_base <= pred_base;
                    r_rd_j    <= r_j;
                    r_j       <= r_j + JW'(1);
                    if (r_j == JW'(MAX_KINDS - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_rd_pend <= 1'b0;
                    r_state   <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                        if (r_full) begin
                            r_m_data <= '0;
                            r_m_user <= 1'b1;
                        end else begin
                            r_m_data <= data_out;
                            r_m_user <= 1'b0;
                            r_amount <= r_cur + AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mcc_checker.sv
// Port checker of the coin change table and its bind statement.
`timescale 1ns / 1ps
`include "min_coin_change_table_defines.svh"

module mcc_checker
    import mcc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    `MCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Result changed while stalled.")
    `MCC_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "A second request was taken while one is in work.")
    `MCC_ASSERT_NOW(a_full_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "Full result carries nonzero data.")
    `MCC_ASSERT_NOW(a_unreach_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[7], m_axis_tdata[62:8] == '0, "Unreachable row carries counts.")
    `MCC_ASSERT_NOW(a_reach_choice, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[62:57] != '0, "Reachable row names no last coin.")

endmodule

bind min_coin_change_table mcc_checker u_mcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
